// File: rtl/sbadpcm_pkg.sv
// Shared types, constants and table functions for the sub-band ADPCM encoder.
// Used by every module of the encoder; depends on nothing.
package sbadpcm_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned QmfTaps = 24;
  localparam int unsigned FifoDepthDefault = 2;

  typedef struct packed {
    logic signed [15:0] xl;
    logic signed [15:0] xh;
  } band_t;

  typedef enum logic [2:0] {
    FR_IDLE, FR_MAC, FR_SUM, FR_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    BK_IDLE, BK_LSEARCH, BK_LQUANT, BK_LPRED, BK_HQUANT, BK_HPRED, BK_OUT
  } back_state_e;

  function automatic logic signed [15:0] qmf_tap(input logic [4:0] i);
    unique case (i)
      5'd0, 5'd23: return 16'sd6;
      5'd1, 5'd2, 5'd21, 5'd22: return -16'sd22;
      5'd3, 5'd20: return 16'sd106;
      5'd4, 5'd19: return 16'sd24;
      5'd5, 5'd18: return -16'sd312;
      5'd6, 5'd17: return 16'sd64;
      5'd7, 5'd16: return 16'sd724;
      5'd8, 5'd15: return -16'sd420;
      5'd9, 5'd14: return -16'sd1610;
      5'd10, 5'd13: return 16'sd1902;
      5'd11, 5'd12: return 16'sd7752;
      default: return 16'sd0;
    endcase
  endfunction

  function automatic logic [11:0] lo_thresh(input logic [4:0] m);
    logic [11:0] t [32];
    t = '{12'd0, 12'd35, 12'd72, 12'd110, 12'd150, 12'd190, 12'd233, 12'd276, 12'd323,
          12'd370, 12'd422, 12'd473, 12'd530, 12'd587, 12'd650, 12'd714, 12'd786, 12'd858,
          12'd940, 12'd1023, 12'd1121, 12'd1219, 12'd1339, 12'd1458, 12'd1612, 12'd1765,
          12'd1980, 12'd2195, 12'd2557, 12'd2919, 12'd0, 12'd0};
    return t[m];
  endfunction

  function automatic logic [5:0] lo_code(input logic pos, input logic [4:0] m);
    logic [5:0] c;
    c = 6'd0;
    if (m != 5'd0 && m != 5'd31) begin
      if (pos) c = 6'd62 - 6'(m);
      else if (m == 5'd1) c = 6'd63;
      else if (m == 5'd2) c = 6'd62;
      else c = 6'd34 - 6'(m);
    end
    return c;
  endfunction

  function automatic logic [2:0] lo_mag4(input logic [3:0] r);
    return r[3] ? 3'(4'd15 - r) : 3'(4'd8 - r);
  endfunction

  function automatic logic [11:0] lo_recon4(input logic [2:0] i);
    logic [11:0] t [8];
    t = '{12'd0, 12'd150, 12'd323, 12'd530, 12'd786, 12'd1121, 12'd1612, 12'd2557};
    return t[i];
  endfunction

  function automatic logic signed [12:0] lo_logstep(input logic [2:0] i);
    logic signed [12:0] t [8];
    t = '{-13'sd60, -13'sd30, 13'sd58, 13'sd172, 13'sd334, 13'sd538, 13'sd1198, 13'sd3042};
    return t[i];
  endfunction

  function automatic logic [11:0] pow2_frac(input logic [4:0] i);
    logic [11:0] t [32];
    t = '{12'd2048, 12'd2093, 12'd2139, 12'd2186, 12'd2233, 12'd2282, 12'd2332, 12'd2383,
          12'd2435, 12'd2489, 12'd2543, 12'd2599, 12'd2656, 12'd2714, 12'd2774, 12'd2834,
          12'd2896, 12'd2960, 12'd3025, 12'd3091, 12'd3158, 12'd3228, 12'd3298, 12'd3371,
          12'd3444, 12'd3520, 12'd3597, 12'd3676, 12'd3756, 12'd3838, 12'd3922, 12'd4008};
    return t[i];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sd32767;
    if (v < -18'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] mulq15(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
    logic signed [31:0] p;
    p = a * b;
    return p[30:15];
  endfunction

  function automatic logic signed [15:0] scale_from_index(input logic [9:0] k);
    logic [4:0]  s;
    logic [31:0] v;
    s = k[9:5];
    v = {20'd0, pow2_frac(k[4:0])};
    if (s <= 5'd10) v = v >> (5'd10 - s);
    else v = v << (s - 5'd10);
    v = v << 2;
    return (v > 32'd32767) ? 16'sd32767 : v[15:0];
  endfunction

endpackage

// File: rtl/sbadpcm_qmf.sv
// QMF analysis front end: shared MAC over the 24-tap delay line, one tap per cycle.
// Depends on sbadpcm_pkg.
module sbadpcm_qmf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [15:0]   first_i,
  input  logic signed [15:0]   second_i,
  output logic                 push_o,
  input  logic                 full_i,
  output sbadpcm_pkg::band_t   band_o
);
  import sbadpcm_pkg::*;

  front_state_e       state_q, state_d;
  logic signed [15:0] dl_q [QmfTaps];
  logic [4:0]         idx_q, idx_d;
  logic signed [31:0] even_q, odd_q, even_d, odd_d;
  logic signed [31:0] prod_s;
  logic signed [32:0] sum_s;
  logic signed [31:0] acc_s;
  logic signed [32:0] lo_s, hi_s;
  logic signed [31:0] lo1, hi1;
  logic signed [32:0] lo2, hi2;
  logic signed [31:0] lo3, hi3;
  logic signed [15:0] xl, xh;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'sh7fffffff;
    if (v < -33'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] clamp15(input logic signed [31:0] v);
    logic signed [15:0] t;
    t = v[31:16];
    if (t > 16'sd16383) t = 16'sd16383;
    if (t < -16'sd16384) t = -16'sd16384;
    return t;
  endfunction

  assign prod_s = qmf_tap(idx_q) * dl_q[idx_q];
  assign acc_s  = idx_q[0] ? odd_q : even_q;
  assign sum_s  = (idx_q < 5'd2) ? 33'(prod_s) : 33'(acc_s) + 33'(prod_s);

  assign lo_s = 33'(even_q) + 33'(odd_q);
  assign hi_s = 33'(even_q) - 33'(odd_q);
  assign lo1  = sat32(lo_s);
  assign hi1  = sat32(hi_s);
  assign lo2  = 33'(lo1) + 33'(lo1);
  assign hi2  = 33'(hi1) + 33'(hi1);
  assign lo3  = sat32(lo2);
  assign hi3  = sat32(hi2);
  assign xl   = clamp15(lo3);
  assign xh   = clamp15(hi3);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    even_d     = even_q;
    odd_d      = odd_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    unique case (state_q)
      FR_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = FR_MAC;
          idx_d   = 5'd0;
        end
      end
      FR_MAC: begin
        if (idx_q[0]) odd_d = sat32(sum_s);
        else even_d = sat32(sum_s);
        if (idx_q == 5'(QmfTaps - 1)) state_d = FR_SUM;
        else idx_d = idx_q + 5'd1;
      end
      FR_SUM: state_d = FR_PUSH;
      FR_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      idx_q   <= '0;
      even_q  <= '0;
      odd_q   <= '0;
      for (int i = 0; i < QmfTaps; i++) dl_q[i] <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      even_q  <= even_d;
      odd_q   <= odd_d;
      if (state_q == FR_IDLE && in_valid_i) begin
        dl_q[1] <= first_i;
        dl_q[0] <= second_i;
      end
      if (state_q == FR_SUM) begin
        for (int i = 2; i < QmfTaps; i++) dl_q[i] <= dl_q[i-2];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FR_SUM) begin
      band_o.xl <= xl;
      band_o.xh <= xh;
    end
  end

  a_push_only_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("push into full queue");
  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == FR_IDLE) else $error("ready outside idle");
  a_mac_then_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FR_MAC && idx_q == 5'(QmfTaps - 1)) |=> state_q == FR_SUM)
    else $error("mac did not finish");
endmodule

// File: rtl/sbadpcm_fifo.sv
// Small queue of band samples between QMF front end and ADPCM back end.
// Depends on sbadpcm_pkg.
module sbadpcm_fifo #(
  parameter int unsigned Depth = sbadpcm_pkg::FifoDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sbadpcm_pkg::band_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output sbadpcm_pkg::band_t rdata_o
);
  import sbadpcm_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  band_t          mem_q [Depth];
  logic [AW-1:0]  wp_q, rp_q;
  logic [AW:0]    cnt_q;

  assign full_o  = cnt_q == (AW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("fifo overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("fifo underflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("fifo count out of range");
endmodule

// File: rtl/sbadpcm_pred.sv
// Sign-sign adaptive predictor of one band (2 poles, 6 zeros), one step per cycle.
// Depends on sbadpcm_pkg.
module sbadpcm_pred (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] dq_i,
  output logic               done_o,
  output logic signed [15:0] pred_o
);
  import sbadpcm_pkg::*;

  logic signed [15:0] pred_q, zpart_q, acc_q;
  logic signed [15:0] pc1_q, pc2_q;
  logic signed [15:0] zc_q [1:6];
  logic signed [15:0] dh_q [0:6];
  logic signed [15:0] pr_q [0:2];
  logic signed [15:0] rc_q [0:2];
  logic [3:0]         step_q;
  logic               busy_q;

  logic               sdq, s0p, s1p, s2p;
  logic signed [15:0] pr0, rc0, t1, t2, t3, t4, t5, p2n, t6, lim, p1n;
  logic signed [17:0] t1w;
  logic signed [15:0] zterm, a_s, b_s, pole;
  logic [2:0]         zi;

  assign pr0 = sat16(18'(dq_i) + 18'(zpart_q));
  assign rc0 = sat16(18'(pred_q) + 18'(dq_i));
  assign s0p = pr0[15];
  assign s1p = pr_q[1][15];
  assign s2p = pr_q[2][15];
  assign sdq = dq_i[15];
  assign t1w = 18'(pc1_q) * 18'sd4;
  assign t1  = sat16(t1w);
  assign t2  = (s0p == s1p) ? sat16(-18'(t1)) : t1;
  assign t3  = t2 >>> 7;
  assign t4  = sat16(18'(t3) + ((s0p == s2p) ? 18'sd128 : -18'sd128));
  assign t5  = sat16(18'(t4) + 18'(mulq15(pc2_q, 16'sd32512)));
  assign p2n = (t5 > 16'sd12288) ? 16'sd12288 : ((t5 < -16'sd12288) ? -16'sd12288 : t5);
  assign t6  = sat16(((s0p == s1p) ? 18'sd192 : -18'sd192) + 18'(mulq15(pc1_q, 16'sd32640)));
  assign lim = sat16(18'sd15360 - 18'(p2n));
  assign p1n = (t6 > lim) ? lim : ((18'(t6) + 18'(lim) < 0) ? -lim : t6);

  assign zi    = 3'(7 - step_q);
  assign zterm = mulq15(sat16(18'(dh_q[zi]) * 18'sd2), zc_q[zi]);
  assign a_s   = mulq15(pc1_q, sat16(18'(rc_q[1]) * 18'sd2));
  assign b_s   = mulq15(pc2_q, sat16(18'(rc_q[2]) * 18'sd2));
  assign pole  = sat16(18'(a_s) + 18'(b_s));

  assign done_o = busy_q && step_q == 4'd7;
  assign pred_o = pred_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q <= '0; zpart_q <= '0; acc_q <= '0; pc1_q <= '0; pc2_q <= '0;
      step_q <= '0; busy_q <= 1'b0;
      for (int i = 1; i <= 6; i++) zc_q[i] <= '0;
      for (int i = 0; i <= 6; i++) dh_q[i] <= '0;
      for (int i = 0; i <= 2; i++) begin pr_q[i] <= '0; rc_q[i] <= '0; end
    end else if (start_i) begin
      for (int i = 1; i <= 6; i++) begin
        zc_q[i] <= sat16(((sdq == dh_q[i][15]) ?
                   ((dq_i == 0) ? 18'sd0 : 18'sd128) :
                   ((dq_i == 0) ? 18'sd0 : -18'sd128)) + 18'(mulq15(zc_q[i], 16'sd32640)));
        dh_q[i] <= (i == 1) ? dq_i : dh_q[i-1];
      end
      dh_q[0] <= dq_i;
      pc2_q   <= p2n;
      pc1_q   <= p1n;
      pr_q[2] <= pr_q[1]; pr_q[1] <= pr0; pr_q[0] <= pr0;
      rc_q[2] <= rc_q[1]; rc_q[1] <= rc0; rc_q[0] <= rc0;
      acc_q   <= '0;
      step_q  <= 4'd1;
      busy_q  <= 1'b1;
    end else if (busy_q) begin
      if (step_q <= 4'd6) begin
        acc_q  <= sat16(18'(acc_q) + 18'(zterm));
        step_q <= step_q + 4'd1;
      end else begin
        zpart_q <= acc_q;
        pred_q  <= sat16(18'(pole) + 18'(acc_q));
        busy_q  <= 1'b0;
      end
    end
  end

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("predictor restarted while busy");
  a_pole2_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc2_q <= 16'sd12288 && pc2_q >= -16'sd12288) else $error("pole 2 out of range");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("predictor did not finish");
endmodule

// File: rtl/sbadpcm_adpcm.sv
// ADPCM back end: quantizer search, scale adaptation and both band predictors.
// Depends on sbadpcm_pkg and sbadpcm_pred.
module sbadpcm_adpcm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  output logic               pop_o,
  input  sbadpcm_pkg::band_t band_i,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata
);
  import sbadpcm_pkg::*;

  back_state_e        state_q, state_d;
  logic signed [15:0] xh_q, el_q, wd_q;
  logic [4:0]         m_q;
  logic [5:0]         cl_q;
  logic [1:0]         ch_q;
  logic signed [15:0] lsc_q, llog_q, hsc_q, hlog_q;
  logic signed [15:0] dql_q, dqh_q;
  logic [7:0]         out_q;

  logic               lstart, hstart, ldone, hdone;
  logic signed [15:0] lpred, hpred;

  logic signed [15:0] el_s, thr, dqmag, dql_s, nbl, nbl_c;
  logic [5:0]         code_s;
  logic [3:0]         r_s;
  logic [2:0]         mg;
  logic signed [15:0] eh, wdh, hthr, dqh_s, nbh, nbh_c, dqh_mag;
  logic [1:0]         hcode;
  logic [1:0]         hmag;

  sbadpcm_pred u_lpred (.clk_i, .rst_ni, .start_i(lstart), .dq_i(dql_q),
                        .done_o(ldone), .pred_o(lpred));
  sbadpcm_pred u_hpred (.clk_i, .rst_ni, .start_i(hstart), .dq_i(dqh_q),
                        .done_o(hdone), .pred_o(hpred));

  assign el_s   = sat16(18'(band_i.xl) - 18'(lpred));
  assign thr    = mulq15(16'(lo_thresh(m_q)) <<< 3, lsc_q);

  assign code_s = lo_code(!el_q[15], m_q);
  assign r_s    = code_s[5:2];
  assign mg     = lo_mag4(r_s);
  assign dqmag  = 16'(lo_recon4(mg)) <<< 3;
  assign dql_s  = mulq15(lsc_q, r_s[3] ? dqmag : -dqmag);
  assign nbl    = sat16(18'(mulq15(llog_q, 16'sd32512)) + 18'(lo_logstep(mg)));
  assign nbl_c  = (nbl < 0) ? 16'sd0 : ((nbl > 16'sd18432) ? 16'sd18432 : nbl);

  assign eh      = sat16(18'(xh_q) - 18'(hpred));
  assign wdh     = eh[15] ? ~eh : eh;
  assign hthr    = mulq15(16'sd4512, hsc_q);
  assign hcode   = {!eh[15], !(wdh >= hthr)};
  assign hmag    = (wdh >= hthr) ? 2'd2 : 2'd1;
  assign dqh_mag = (hmag == 2'd2) ? 16'sd7408 : 16'sd1616;
  assign dqh_s   = mulq15(eh[15] ? -dqh_mag : dqh_mag, hsc_q);
  assign nbh     = sat16(18'(mulq15(hlog_q, 16'sd32512)) +
                   ((hmag == 2'd2) ? 18'sd798 : -18'sd214));
  assign nbh_c   = (nbh < 0) ? 16'sd0 : ((nbh > 16'sd22528) ? 16'sd22528 : nbh);

  assign m_axis_tvalid = state_q == BK_OUT;
  assign m_axis_tdata  = out_q;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    lstart  = 1'b0;
    hstart  = 1'b0;
    unique case (state_q)
      BK_IDLE: if (!empty_i) begin
        pop_o   = 1'b1;
        state_d = BK_LSEARCH;
      end
      BK_LSEARCH: if (thr > wd_q || m_q == 5'd30) state_d = BK_LQUANT;
      BK_LQUANT: state_d = BK_LPRED;
      BK_LPRED: begin
        lstart  = 1'b1;
        state_d = BK_HQUANT;
      end
      BK_HQUANT: if (ldone) state_d = BK_HPRED;
      BK_HPRED: begin
        hstart  = 1'b1;
        state_d = BK_OUT;
      end
      BK_OUT: if (m_axis_tready) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      lsc_q <= 16'sd32; hsc_q <= 16'sd8; llog_q <= '0; hlog_q <= '0;
      m_q <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        BK_IDLE: m_q <= '0;
        BK_LSEARCH: if (!(thr > wd_q || m_q == 5'd30)) m_q <= m_q + 5'd1;
        BK_LQUANT: begin
          llog_q <= nbl_c;
          lsc_q  <= scale_from_index(10'(nbl_c[14:6]) + 10'd64);
        end
        BK_HQUANT: if (ldone) begin
          hlog_q <= nbh_c;
          hsc_q  <= scale_from_index(10'(nbh_c[14:6]));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE) begin
      el_q <= el_s;
      wd_q <= el_s[15] ? ~el_s : el_s;
      xh_q <= band_i.xh;
    end
    if (state_q == BK_LQUANT) begin
      cl_q  <= code_s;
      dql_q <= dql_s;
    end
    if (state_q == BK_HQUANT && ldone) begin
      ch_q  <= hcode;
      dqh_q <= dqh_s;
    end
    if (state_q == BK_HPRED) out_q <= {ch_q, cl_q};
  end

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == BK_IDLE && !empty_i) else $error("pop outside idle");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(out_q)) else $error("output changed");
  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_q <= 5'd30) else $error("search index out of range");
  a_scale_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lsc_q >= 16'sd8) else $error("low scale too small");
endmodule

// File: rtl/subband_adpcm_speech_encoder_core.sv
// Top level of the 64 kbit/s sub-band ADPCM speech encoder.
// Depends on sbadpcm_pkg, sbadpcm_qmf, sbadpcm_fifo and sbadpcm_adpcm.
//
// One input word carries a pair of 16-bit PCM samples; one output word carries
// the 8-bit codeword for that pair (high band in bits 7..6, low band in 5..0).
// The QMF front end takes a word, runs its 24 taps through one shared
// multiplier and pushes the band pair into a two-entry queue before it takes
// the next word. The back end pops a pair, searches the low-band quantizer
// one interval per cycle, then runs the low and high predictors, each of
// which walks its six zero taps one per cycle, and pops the next pair only
// once its codeword has been taken. A steady stream moves at the pace of
// whichever of the two ends is slower.
// The front end keeps taking words while the back end works and while a
// codeword waits, until the queue is full. Reset clears all filter history
// and predictor state, resets the scale factors and empties the queue. A
// stalled master side holds tvalid and tdata steady until the word is taken.
module subband_adpcm_speech_encoder_core #(
  parameter int unsigned FifoDepth = sbadpcm_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] first_sample, [31:16] second_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [7:0] codeword
);
  import sbadpcm_pkg::*;

  logic  push, full, pop, empty;
  band_t band_w, band_r;

  sbadpcm_qmf u_qmf (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .first_i(s_axis_tdata[15:0]), .second_i(s_axis_tdata[31:16]),
    .push_o(push), .full_i(full), .band_o(band_w)
  );

  sbadpcm_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(band_w), .full_o(full),
    .pop_i(pop), .empty_o(empty), .rdata_o(band_r)
  );

  sbadpcm_adpcm u_adpcm (
    .clk_i, .rst_ni, .empty_i(empty), .pop_o(pop), .band_i(band_r),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );
endmodule
